/* design/tla_pkg.sv */
// Tank level alarm: shared types, opcodes, register indexes and constants.
// Used by tla_ctrl, tla_dp, tank_level_alarm_hysteresis and the testbench. No dependencies.
`default_nettype none

package tla_pkg;

  localparam int LEVEL_W   = 16;
  localparam int PCT_W     = 8;
  localparam int MASK_W    = 3;
  localparam int OP_W      = 2;
  localparam int CH_W      = 2;
  localparam int IDX_W     = 3;
  localparam int SETUP_W   = 39;
  localparam int ALARM_W   = 7;
  localparam int MUTE_W    = 16;
  localparam int IN_USER_W = OP_W + CH_W;
  localparam int OUT_DATA_W = 24;

  // (level - min) * 100 fits in 24 signed bits; its magnitude in 23
  localparam int PROD_W    = 24;
  localparam int QUO_W     = PROD_W - 1;
  localparam int DIV_STEPS = QUO_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int PCT_SCALE = 100;
  localparam int CLR_SCALE = 105;
  localparam int PCT_FULL  = 100;
  localparam int PCT_MAX   = 127;
  localparam int PCT_MIN   = -128;

  localparam logic [MUTE_W-1:0] MUTE_RESET = 16'd12000;

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_BUTTON = 2'd1,
    OP_TICK   = 2'd2,
    OP_PULSE  = 2'd3
  } op_t;

  typedef enum logic [IDX_W-1:0] {
    REG_ACTIVE = 3'd0,
    REG_SETUP0 = 3'd1,
    REG_SETUP1 = 3'd2,
    REG_SETUP2 = 3'd3,
    REG_MUTE   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic update;
  } tla_cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } tla_sts_t;

endpackage

`default_nettype wire

/* design/tla_ctrl.sv */
// Tank level alarm: sequencer for load, scale, divide and update steps.
// Depends on tla_pkg; drives tla_dp through tla_cmd_t.
`default_nettype none

module tla_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire tla_pkg::tla_sts_t  sts,
  output tla_pkg::tla_cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_UPD
  } state_t;

  localparam logic [tla_pkg::DIV_CNT_W-1:0] CNT_LAST =
    tla_pkg::DIV_CNT_W'(tla_pkg::DIV_STEPS - 1);

  state_t                         state_r;
  logic [tla_pkg::DIV_CNT_W-1:0]  cnt_r;

  always_comb begin
    in_tready  = (state_r == S_IDLE);
    cmd        = '0;
    cmd.load   = in_tvalid && in_tready;
    cmd.mul    = (state_r == S_MUL);
    cmd.step   = (state_r == S_DIV);
    cmd.update = (state_r == S_UPD) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cmd.load) state_r <= S_MUL;
        end
        S_MUL: begin
          cnt_r   <= '0;
          state_r <= sts.need_div ? S_DIV : S_UPD;
        end
        S_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_LAST) state_r <= S_UPD;
        end
        S_UPD: begin
          if (sts.out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == CNT_LAST) |=> state_r == S_UPD)
    else $error("divide did not end after its last step");

  a_upd_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && !sts.out_free) |=> state_r == S_UPD)
    else $error("update left while output register full");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_MUL && !in_tready))
    else $error("accepted item did not start scaling");
`endif

endmodule

`default_nettype wire

/* design/tla_dp.sv */
// Tank level alarm datapath: config registers, percent scaling, restoring
// divider, alarm/latch state and output register. Depends on tla_pkg.
`default_nettype none

module tla_dp #(
  parameter int CHANNELS = 3
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [tla_pkg::IDX_W-1:0]          cfg_index,
  input  wire logic [tla_pkg::SETUP_W-1:0]        cfg_data,
  input  wire logic [tla_pkg::LEVEL_W-1:0]        in_tdata,
  input  wire logic [tla_pkg::IN_USER_W-1:0]      in_tuser,
  input  wire tla_pkg::tla_cmd_t                  cmd,
  output tla_pkg::tla_sts_t                       sts,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [tla_pkg::OUT_DATA_W-1:0]          out_tdata
);

  // configuration
  logic [tla_pkg::MASK_W-1:0]   active_r;
  logic [tla_pkg::SETUP_W-1:0]  setup_r [CHANNELS];
  logic [tla_pkg::MUTE_W-1:0]   mute_ticks_r;

  // captured item
  tla_pkg::op_t                 op_r;
  logic [tla_pkg::CH_W-1:0]     ch_r;
  logic [tla_pkg::LEVEL_W-1:0]  lvl_r;

  // divider
  logic [tla_pkg::QUO_W-1:0]    q_r;
  logic [tla_pkg::LEVEL_W-1:0]  rem_r;
  logic [tla_pkg::LEVEL_W-1:0]  den_r;
  logic                         neg_r;
  logic                         zero_r;

  // alarm state
  logic [CHANNELS-1:0]          warn_r, warn_nxt;
  logic [CHANNELS-1:0]          led_r, led_nxt;
  logic [CHANNELS-1:0]          buzz_r, buzz_nxt;
  logic [tla_pkg::MUTE_W-1:0]   mute_r, mute_nxt;
  logic                         led_lvl_r, led_lvl_nxt;
  logic                         bz_lvl_r, bz_lvl_nxt;

  logic                         out_tvalid_r;
  logic [tla_pkg::OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic [CHANNELS-1:0]          sel;
  logic [tla_pkg::SETUP_W-1:0]  setup_sel;
  logic [tla_pkg::LEVEL_W-1:0]  lo, hi;
  logic [tla_pkg::ALARM_W-1:0]  alarm;
  logic                         need_div;

  logic signed [tla_pkg::LEVEL_W:0]     diff, span;
  logic signed [tla_pkg::PROD_W-1:0]    prod;
  logic [tla_pkg::QUO_W-1:0]            prod_mag;
  logic [tla_pkg::LEVEL_W-1:0]          den_mag;

  logic [tla_pkg::LEVEL_W:0]            rem_sh;
  logic                                 q_bit;

  logic signed [tla_pkg::PROD_W-1:0]    p_val;
  logic signed [31:0]                   p100, a105;
  logic                                 lt, clr;
  logic [tla_pkg::PCT_W-1:0]            pct_sat, pct_out;
  logic                                 any_led, any_bz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= '0;
      mute_ticks_r <= tla_pkg::MUTE_RESET;
      for (int n = 0; n < CHANNELS; n++) setup_r[n] <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == tla_pkg::REG_ACTIVE) active_r <= cfg_data[tla_pkg::MASK_W-1:0];
      if (cfg_index == tla_pkg::REG_MUTE) mute_ticks_r <= cfg_data[tla_pkg::MUTE_W-1:0];
      for (int n = 0; n < CHANNELS; n++) begin
        if (cfg_index == tla_pkg::IDX_W'(int'(tla_pkg::REG_SETUP0) + n)) setup_r[n] <= cfg_data;
      end
    end
  end

  always_comb begin
    setup_sel = '0;
    for (int n = 0; n < CHANNELS; n++) begin
      sel[n] = (ch_r == tla_pkg::CH_W'(n));
      if (sel[n]) setup_sel = setup_r[n];
    end
    lo       = setup_sel[15:0];
    hi       = setup_sel[31:16];
    alarm    = setup_sel[38:32];
    need_div = (op_r == tla_pkg::OP_SAMPLE) && (|(sel & active_r[CHANNELS-1:0]));
  end

  // scale step: (level - min) * 100 and the signed span
  always_comb begin
    diff     = $signed({1'b0, lvl_r}) - $signed({1'b0, lo});
    span     = $signed({1'b0, hi}) - $signed({1'b0, lo});
    prod     = tla_pkg::PROD_W'(diff) * tla_pkg::PROD_W'(tla_pkg::PCT_SCALE);
    prod_mag = prod[tla_pkg::PROD_W-1] ? tla_pkg::QUO_W'(-prod) : prod[tla_pkg::QUO_W-1:0];
    den_mag  = span[tla_pkg::LEVEL_W] ? tla_pkg::LEVEL_W'(-span) : span[tla_pkg::LEVEL_W-1:0];
  end

  // one restoring step per cycle
  always_comb begin
    rem_sh = {rem_r, q_r[tla_pkg::QUO_W-1]};
    q_bit  = (rem_sh >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= tla_pkg::op_t'(in_tuser[tla_pkg::OP_W-1:0]);
      ch_r  <= in_tuser[tla_pkg::IN_USER_W-1:tla_pkg::OP_W];
      lvl_r <= in_tdata;
    end
    if (cmd.mul) begin
      q_r    <= prod_mag;
      rem_r  <= '0;
      den_r  <= den_mag;
      neg_r  <= prod[tla_pkg::PROD_W-1] ^ span[tla_pkg::LEVEL_W];
      zero_r <= (span == '0);
    end else if (cmd.step) begin
      q_r   <= {q_r[tla_pkg::QUO_W-2:0], q_bit};
      rem_r <= q_bit ? tla_pkg::LEVEL_W'(rem_sh - {1'b0, den_r})
                     : rem_sh[tla_pkg::LEVEL_W-1:0];
    end
  end

  // compare and saturate
  always_comb begin
    if (zero_r) p_val = '0;
    else if (neg_r) p_val = -$signed({1'b0, q_r});
    else p_val = $signed({1'b0, q_r});
    p100 = 32'(p_val) * 32'sd100;
    a105 = $signed(32'(alarm)) * 32'(tla_pkg::CLR_SCALE);
    lt   = p_val < $signed(tla_pkg::PROD_W'(alarm));
    clr  = (p100 >= a105) || (p_val >= tla_pkg::PROD_W'(tla_pkg::PCT_FULL));
    priority if (p_val > tla_pkg::PROD_W'(tla_pkg::PCT_MAX)) pct_sat = tla_pkg::PCT_W'(tla_pkg::PCT_MAX);
    else if (p_val < tla_pkg::PROD_W'(tla_pkg::PCT_MIN)) pct_sat = tla_pkg::PCT_W'(tla_pkg::PCT_MIN);
    else pct_sat = p_val[tla_pkg::PCT_W-1:0];
    pct_out = need_div ? pct_sat : '0;
    any_led = |(led_r & active_r[CHANNELS-1:0]);
    any_bz  = |(buzz_r & active_r[CHANNELS-1:0]);
  end

  always_comb begin
    warn_nxt    = warn_r;
    led_nxt     = led_r;
    buzz_nxt    = buzz_r;
    mute_nxt    = mute_r;
    led_lvl_nxt = led_lvl_r;
    bz_lvl_nxt  = bz_lvl_r;
    if (cmd.update) begin
      unique case (op_r)
        tla_pkg::OP_SAMPLE: begin
          for (int n = 0; n < CHANNELS; n++) begin
            if (need_div && sel[n]) begin
              if (lt) begin
                if (!warn_r[n]) begin
                  led_nxt[n] = 1'b1;
                  if (mute_r == '0) buzz_nxt[n] = 1'b1;
                end
                warn_nxt[n] = 1'b1;
              end else if (clr) begin
                warn_nxt[n] = 1'b0;
                led_nxt[n]  = 1'b0;
                buzz_nxt[n] = 1'b0;
              end
            end
          end
        end
        tla_pkg::OP_BUTTON: begin
          buzz_nxt   = '0;
          bz_lvl_nxt = 1'b0;
          mute_nxt   = mute_ticks_r;
        end
        tla_pkg::OP_TICK: begin
          if (mute_r != '0) mute_nxt = mute_r - 1'b1;
        end
        tla_pkg::OP_PULSE: begin
          led_lvl_nxt = any_led ? !led_lvl_r : 1'b0;
          bz_lvl_nxt  = any_bz ? !bz_lvl_r : 1'b0;
        end
        default: ;
      endcase
    end
    out_tdata_nxt = {4'b0, (mute_nxt != '0), bz_lvl_nxt, led_lvl_nxt,
                     tla_pkg::MASK_W'(buzz_nxt), tla_pkg::MASK_W'(led_nxt),
                     tla_pkg::MASK_W'(warn_nxt), pct_out};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warn_r       <= '0;
      led_r        <= '0;
      buzz_r       <= '0;
      mute_r       <= '0;
      led_lvl_r    <= 1'b0;
      bz_lvl_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      warn_r    <= warn_nxt;
      led_r     <= led_nxt;
      buzz_r    <= buzz_nxt;
      mute_r    <= mute_nxt;
      led_lvl_r <= led_lvl_nxt;
      bz_lvl_r  <= bz_lvl_nxt;
      if (cmd.update) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) out_tdata_r <= out_tdata_nxt;
  end

  always_comb begin
    sts          = '0;
    sts.need_div = need_div;
    sts.out_free = !out_tvalid_r || out_tready;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  a_led_in_warn: assert property (@(posedge clk) disable iff (!rst_n)
    (led_r & ~warn_r) == '0)
    else $error("LED latch set outside warning");

  a_buzz_in_led: assert property (@(posedge clk) disable iff (!rst_n)
    (buzz_r & ~led_r) == '0)
    else $error("buzzer latch set without LED latch");

  a_update_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> out_tvalid_r)
    else $error("update did not present an item");

  a_mute_down: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.update && op_r == tla_pkg::OP_BUTTON) |=> mute_r <= $past(mute_r))
    else $error("mute count rose without a button item");
`endif

endmodule

`default_nettype wire

/* design/tank_level_alarm_hysteresis.sv */
// Tank level alarm with hysteresis and buzzer mute: top level.
// Depends on tla_pkg, tla_ctrl and tla_dp.
//
//   channel  ports                         payload
//   in       in_tvalid/in_tready           tdata: level; tuser: op, channel
//   out      out_tvalid/out_tready         tdata: percent, masks, drives, muted
//   cfg      cfg_wr_en/cfg_index/cfg_data  one register per write
//
// A sample for an active channel goes from accept to result through load, scale,
// 23 steps of the restoring divider and update. Other items skip the divider.
// One item is in flight at a time; the next is accepted while a result waits.
// Synchronous active-low reset; config registers return to their defaults.
// A stalled output holds the update step until the output register frees.
`default_nettype none

module tank_level_alarm_hysteresis #(
  parameter int CHANNELS = 3
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [tla_pkg::IDX_W-1:0]       cfg_index,
  input  wire logic [tla_pkg::SETUP_W-1:0]     cfg_data,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [tla_pkg::LEVEL_W-1:0]     in_tdata,  // level[15:0]
  input  wire logic [tla_pkg::IN_USER_W-1:0]   in_tuser,  // op[1:0], channel[3:2]
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // percent[7:0], warn_mask[10:8], led_latch_mask[13:11],
  // buzzer_latch_mask[16:14], led_out[17], buzzer_out[18], muted[19], zero[23:20]
  output logic [tla_pkg::OUT_DATA_W-1:0]       out_tdata
);

  tla_pkg::tla_cmd_t cmd;
  tla_pkg::tla_sts_t sts;

  tla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tla_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for tank_level_alarm_hysteresis: predicts one status item per
// input item and compares it with the out stream. Depends on tla_pkg and the design sources.
// Directed items first, then random phases with new register settings between them.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tla_pkg::*;

  localparam int CHANNELS = 3;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    op_t         op;
    logic [1:0]  chan;
    logic [15:0] level;
  } sensor_item_t;

  // matches the out_tdata layout, lowest field last
  typedef struct packed {
    logic [3:0] spare;
    logic       muted;
    logic       buzzer_out;
    logic       led_out;
    logic [2:0] buzzer_mask;
    logic [2:0] led_mask;
    logic [2:0] warn_mask;
    logic [7:0] percent;
  } alarm_status_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [SETUP_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [LEVEL_W-1:0] in_tdata = '0;    // level[15:0]
  logic [IN_USER_W-1:0] in_tuser = '0;  // op[1:0], channel[3:2]
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;     // percent, warn, led, buzzer masks, drives, muted

  tank_level_alarm_hysteresis #(.CHANNELS(CHANNELS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // predicted registers and alarm state
  logic [2:0]  alarm_active = '0;
  logic [38:0] chan_setup [CHANNELS] = '{default: '0};
  logic [15:0] mute_load = MUTE_RESET;
  logic [2:0]  warn_mode = '0;
  logic [2:0]  led_latch = '0;
  logic [2:0]  buzzer_latch = '0;
  logic [15:0] mute_left = '0;
  logic        led_level = 1'b0;
  logic        buzzer_level = 1'b0;

  sensor_item_t  pending_items [$];
  alarm_status_t expected_status [$];
  sensor_item_t  in_cur;
  int items_open = 0;
  int mismatches = 0;
  int in_gap = 0;
  int out_stall = 0;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int unsigned cycle_count = 0;

  function automatic alarm_status_t alarm_predict(sensor_item_t it);
    alarm_status_t r;
    longint lo, hi, span, pct, alarm;
    r = '0;
    pct = 0;
    case (it.op)
      OP_SAMPLE: begin
        if (it.chan < CHANNELS) begin
          if (alarm_active[it.chan]) begin
            lo = chan_setup[it.chan][15:0];
            hi = chan_setup[it.chan][31:16];
            alarm = chan_setup[it.chan][38:32];
            span = hi - lo;
            pct = (span == 0) ? 0 : ((longint'(it.level) - lo) * 100) / span;
            if (pct < alarm) begin
              if (!warn_mode[it.chan]) begin
                led_latch[it.chan] = 1'b1;
                if (mute_left == 0) buzzer_latch[it.chan] = 1'b1;
              end
              warn_mode[it.chan] = 1'b1;
            end else if (pct * 100 >= alarm * 105 || pct >= 100) begin
              warn_mode[it.chan] = 1'b0;
              led_latch[it.chan] = 1'b0;
              buzzer_latch[it.chan] = 1'b0;
            end
          end
        end
      end
      OP_BUTTON: begin
        buzzer_latch = '0;
        buzzer_level = 1'b0;
        mute_left = mute_load;
      end
      OP_TICK: begin
        if (mute_left != 0) mute_left--;
      end
      default: begin
        led_level = |(led_latch & alarm_active) ? ~led_level : 1'b0;
        buzzer_level = |(buzzer_latch & alarm_active) ? ~buzzer_level : 1'b0;
      end
    endcase
    r.percent = (pct > 127) ? 8'h7F : (pct < -128) ? 8'h80 : 8'(pct);
    r.warn_mask = warn_mode;
    r.led_mask = led_latch;
    r.buzzer_mask = buzzer_latch;
    r.led_out = led_level;
    r.buzzer_out = buzzer_level;
    r.muted = (mute_left != 0);
    return r;
  endfunction

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  task automatic compare_status(alarm_status_t e, alarm_status_t a);
    check_field("percent", e.percent, a.percent);
    check_field("warn_mask", e.warn_mask, a.warn_mask);
    check_field("led_latch_mask", e.led_mask, a.led_mask);
    check_field("buzzer_latch_mask", e.buzzer_mask, a.buzzer_mask);
    check_field("led_out", e.led_out, a.led_out);
    check_field("buzzer_out", e.buzzer_out, a.buzzer_out);
    check_field("muted", e.muted, a.muted);
    check_field("spare", e.spare, a.spare);
  endtask

  task automatic add_item(op_t op, logic [1:0] chan, logic [15:0] level);
    sensor_item_t it;
    it.op = op;
    it.chan = chan;
    it.level = level;
    pending_items.push_back(it);
    items_open++;
  endtask

  task automatic write_reg(reg_idx_t idx, logic [38:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_ACTIVE: alarm_active = value[2:0];
      REG_SETUP0: chan_setup[0] = value;
      REG_SETUP1: chan_setup[1] = value;
      REG_SETUP2: chan_setup[2] = value;
      REG_MUTE:   mute_load = value[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain_results();
    do @(posedge clk); while (items_open != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_tvalid && in_tready) expected_status.push_back(alarm_predict(in_cur));
      if (!in_tvalid || in_tready) begin
        if (in_gap == 0 && in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct)
          in_gap = $urandom_range(1, 18);
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_cur = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= in_cur.level;
          in_tuser <= {in_cur.chan, in_cur.op};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_status.size() == 0) begin
          $display("%0t: result %h with no item outstanding", $time, out_tdata);
          mismatches++;
        end else begin
          compare_status(expected_status.pop_front(), alarm_status_t'(out_tdata));
          items_open--;
        end
      end
      if (out_stall == 0 && out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct)
        out_stall = $urandom_range(1, 18);
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    int k, n;
    int unsigned w;
    logic [15:0] lo, hi;
    logic [6:0] alarm;
    longint tgt, lv;
    sensor_item_t it;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    in_idle_pct = 8;
    out_stall_pct = 8;

    // default mute load after reset
    add_item(OP_BUTTON, 2'd0, 16'd0);
    drain_results();

    write_reg(REG_ACTIVE, 39'h7);
    write_reg(REG_SETUP0, {7'd30, 16'd2000, 16'd1000});
    write_reg(REG_SETUP1, {7'd127, 16'hFFFF, 16'h0000});
    write_reg(REG_SETUP2, {7'd50, 16'd1000, 16'd5000});  // reversed range
    write_reg(REG_MUTE, 39'd3);
    add_item(OP_BUTTON, 2'd1, 16'hFFFF);
    add_item(OP_SAMPLE, 2'd0, 16'd1200);   // warn while muted
    repeat (4) add_item(OP_TICK, 2'd2, 16'h5A5A);  // last one ticks at zero
    add_item(OP_SAMPLE, 2'd0, 16'd1500);
    add_item(OP_SAMPLE, 2'd0, 16'd1200);
    add_item(OP_PULSE, 2'd0, 16'd0);
    add_item(OP_PULSE, 2'd0, 16'd0);
    add_item(OP_SAMPLE, 2'd0, 16'd1310);   // inside hysteresis band
    add_item(OP_SAMPLE, 2'd0, 16'd1320);
    add_item(OP_SAMPLE, 2'd0, 16'd0);      // negative percent
    add_item(OP_SAMPLE, 2'd1, 16'd0);
    add_item(OP_SAMPLE, 2'd0, 16'hFFFF);   // saturates high
    add_item(OP_SAMPLE, 2'd2, 16'hFFFF);   // saturates low
    add_item(OP_SAMPLE, 2'd2, 16'd0);
    add_item(OP_SAMPLE, 2'd3, 16'd100);    // no such channel
    add_item(OP_PULSE, 2'd3, 16'hFFFF);
    drain_results();

    write_reg(REG_ACTIVE, 39'h2);
    write_reg(REG_SETUP1, {7'd10, 16'd777, 16'd777});  // empty range
    write_reg(REG_MUTE, 39'd0);
    add_item(OP_SAMPLE, 2'd1, 16'd500);
    add_item(OP_SAMPLE, 2'd0, 16'd1000);   // inactive channel
    add_item(OP_PULSE, 2'd0, 16'd0);
    add_item(OP_BUTTON, 2'd0, 16'd0);      // zero mute load
    drain_results();

    for (k = 0; k < 8; k++) begin
      for (n = 0; n < CHANNELS; n++) begin
        w = $urandom_range(0, 9);
        if (w == 0) begin
          lo = 16'h0000;
          hi = 16'hFFFF;
        end else if (w == 1) begin
          lo = 16'($urandom);
          hi = lo;
        end else if (w == 2) begin
          lo = 16'($urandom);
          hi = 16'($urandom);
        end else begin
          lo = 16'($urandom_range(0, 60000));
          hi = lo + 16'($urandom_range(1, 65535 - lo));
        end
        alarm = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(5, 95));
        write_reg(reg_idx_t'(REG_SETUP0 + n), {alarm, hi, lo});
      end
      write_reg(REG_ACTIVE, {36'($urandom),
                (k == 0 || k == 7) ? 3'b111 : (k == 3) ? 3'b000 : 3'($urandom)});
      write_reg(REG_MUTE, {23'($urandom),
                (k == 2) ? 16'hFFFF : (k == 4) ? 16'h0000 : 16'($urandom_range(1, 40))});
      write_reg(reg_idx_t'(REG_MUTE + $urandom_range(1, 3)), {7'($urandom), 32'($urandom)});
      in_idle_pct = (k == 1 || k == 7) ? 0 : $urandom_range(2, 12);
      out_stall_pct = (k == 5 || k == 7) ? 0 : $urandom_range(2, 12);

      for (n = 0; n < 240; n++) begin
        w = $urandom_range(0, 99);
        it.op = (w < 50) ? OP_SAMPLE : (w < 75) ? OP_PULSE : (w < 93) ? OP_TICK : OP_BUTTON;
        it.chan = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        it.level = 16'($urandom);
        if (it.op == OP_SAMPLE && it.chan != 2'd3 && $urandom_range(0, 3) != 0) begin
          // aim near the alarm and clear thresholds
          tgt = longint'(chan_setup[it.chan][38:32]) + int'($urandom_range(0, 12)) - 6;
          lv = longint'(chan_setup[it.chan][15:0]) +
               (longint'(chan_setup[it.chan][31:16]) - longint'(chan_setup[it.chan][15:0]))
               * tgt / 100;
          it.level = (lv < 0) ? 16'h0000 : (lv > 65535) ? 16'hFFFF : 16'(lv);
        end else if ($urandom_range(0, 7) == 0) begin
          it.level = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        add_item(it.op, it.chan, it.level);
      end
      drain_results();
    end

    if (expected_status.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
design/tla_pkg.sv
design/tla_ctrl.sv
design/tla_dp.sv
design/tank_level_alarm_hysteresis.sv
verif/testbench.sv
